// ===== design/thmd_pkg.sv =====
// shared constants and permutation table for the table hash digest core
package thmd_pkg;

    localparam int DIGEST_MAX_DEF = 32;
    localparam int RESULT_LIMIT   = 32;
    localparam int LEN_W          = 6;
    localparam int IDX_W          = 5;
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd16;

    localparam logic [7:0] PERM [0:255] = '{
        8'h01, 8'h0E, 8'h6E, 8'h19, 8'h61, 8'hAE, 8'h84, 8'h77,
        8'h8A, 8'hAA, 8'h7D, 8'h76, 8'h1B, 8'hE9, 8'h8C, 8'h33,
        8'h57, 8'hC5, 8'hB1, 8'h6B, 8'hEA, 8'hA9, 8'h38, 8'h44,
        8'h1E, 8'h07, 8'hAD, 8'h49, 8'hBC, 8'h28, 8'h24, 8'h41,
        8'h31, 8'hD5, 8'h68, 8'hBE, 8'h39, 8'hD3, 8'h94, 8'hDF,
        8'h30, 8'h73, 8'h0F, 8'h02, 8'h43, 8'hBA, 8'hD2, 8'h1C,
        8'h0C, 8'hB5, 8'h67, 8'h46, 8'h16, 8'h3A, 8'h4B, 8'h4E,
        8'hB7, 8'hA7, 8'hEE, 8'h9D, 8'h7C, 8'h93, 8'hAC, 8'h90,
        8'hB0, 8'hA1, 8'h8D, 8'h56, 8'h3C, 8'h42, 8'h80, 8'h53,
        8'h9C, 8'hF1, 8'h4F, 8'h2E, 8'hA8, 8'hC6, 8'h29, 8'hFE,
        8'hB2, 8'h55, 8'hFD, 8'hED, 8'hFA, 8'h9A, 8'h85, 8'h58,
        8'h23, 8'hCE, 8'h5F, 8'h74, 8'hFC, 8'hC0, 8'h36, 8'hDD,
        8'h66, 8'hDA, 8'hFF, 8'hF0, 8'h52, 8'h6A, 8'h9E, 8'hC9,
        8'h3D, 8'h03, 8'h59, 8'h09, 8'h2A, 8'h9B, 8'h9F, 8'h5D,
        8'hA6, 8'h50, 8'h32, 8'h22, 8'hAF, 8'hC3, 8'h64, 8'h63,
        8'h1A, 8'h96, 8'h10, 8'h91, 8'h04, 8'h21, 8'h08, 8'hBD,
        8'h79, 8'h40, 8'h4D, 8'h48, 8'hD0, 8'hF5, 8'h82, 8'h7A,
        8'h8F, 8'h37, 8'h69, 8'h86, 8'h1D, 8'hA4, 8'hB9, 8'hC2,
        8'hC1, 8'hEF, 8'h65, 8'hF2, 8'h05, 8'hAB, 8'h7E, 8'h0B,
        8'h4A, 8'h3B, 8'h89, 8'hE4, 8'h6C, 8'hBF, 8'hE8, 8'h8B,
        8'h06, 8'h18, 8'h51, 8'h14, 8'h7F, 8'h11, 8'h5B, 8'h5C,
        8'hFB, 8'h97, 8'hE1, 8'hCF, 8'h15, 8'h62, 8'h71, 8'h70,
        8'h54, 8'hE2, 8'h12, 8'hD6, 8'hC7, 8'hBB, 8'h0D, 8'h20,
        8'h5E, 8'hDC, 8'hE0, 8'hD4, 8'hF7, 8'hCC, 8'hC4, 8'h2B,
        8'hF9, 8'hEC, 8'h2D, 8'hF4, 8'h6F, 8'hB6, 8'h99, 8'h88,
        8'h81, 8'h5A, 8'hD9, 8'hCA, 8'h13, 8'hA5, 8'hE7, 8'h47,
        8'hE6, 8'h8E, 8'h60, 8'hE3, 8'h3E, 8'hB3, 8'hF6, 8'h72,
        8'hA2, 8'h35, 8'hA0, 8'hD7, 8'hCD, 8'hB4, 8'h2F, 8'h6D,
        8'h2C, 8'h26, 8'h1F, 8'h95, 8'h87, 8'h00, 8'hD8, 8'h34,
        8'h3F, 8'h17, 8'h25, 8'h45, 8'h27, 8'h75, 8'h92, 8'hB8,
        8'hA3, 8'hC8, 8'hDE, 8'hEB, 8'hF8, 8'hF3, 8'hDB, 8'h0A,
        8'h98, 8'h83, 8'h7B, 8'hE5, 8'hCB, 8'h4C, 8'h78, 8'hD1
    };

endpackage

// ===== design/table_hash_multibyte_digest_core.sv =====
// table hash digest core: digest store memory, read-modify-write sequencer, digest emission
//
// Each accepted item makes one pass over the digest memory: DIGEST_MAX reads, each followed in
// the next cycle by the write of the updated entry; busy stays high through the pass and the
// drain state after it, paced by the single read and write ports of the memory. An item
// marked last then streams the digest, highest index first, one beat per cycle for n beats,
// where n is digest_len clamped to 1..min(DIGEST_MAX, 32); busy drops as the final read is
// issued, so the last beat appears in the first idle cycle. Each beat is on the result ports
// for exactly one cycle with strobe high and cannot be held off by the receiver. The first
// item of a message seeds entry i with i during its pass. The user must write digest_len through
// cfg_we/cfg_data only while busy is low and no beats are pending; the block never checks it.
module table_hash_multibyte_digest_core
    import thmd_pkg::*;
#(
    parameter int DIGEST_MAX = DIGEST_MAX_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [7:0]       data_byte,
    input  logic             byte_valid,
    input  logic             last,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data,
    output logic             strobe,
    output logic [7:0]       digest_byte,
    output logic [IDX_W-1:0] byte_index,
    output logic             digest_last
);

    localparam int AW  = (DIGEST_MAX > 1) ? $clog2(DIGEST_MAX) : 1;
    localparam int LIM = (DIGEST_MAX < RESULT_LIMIT) ? DIGEST_MAX : RESULT_LIMIT;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_HASH   = 2'd1;
    localparam logic [1:0] S_HDRAIN = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [7:0]       mem [0:DIGEST_MAX-1];
    logic [7:0]       rd_data_reg;

    logic [1:0]       state_reg, state_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0] ecnt_reg, ecnt_next;
    logic             wr_pend_reg, wr_pend_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;
    logic             started_reg, started_next;
    logic [LEN_W-1:0] len_reg;
    logic             strobe_reg, strobe_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [7:0]       byte_reg;
    logic             valid_reg;
    logic             last_reg;
    logic             seed_reg;

    logic [AW-1:0]    rd_addr;
    logic [7:0]       old_val;
    logic [7:0]       wr_data;
    logic [LEN_W-1:0] len_eff;
    logic             accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // length clamp
    always_comb
    begin
        if (len_reg == '0)
            len_eff = LEN_W'(1);
        else if (len_reg > LEN_W'(LIM))
            len_eff = LEN_W'(LIM);
        else
            len_eff = len_reg;
    end

    // entry update
    always_comb
    begin
        old_val = seed_reg ? 8'(wr_addr_reg) : rd_data_reg;
        wr_data = valid_reg ? PERM[byte_reg ^ old_val] : old_val;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ecnt_next    = ecnt_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = cnt_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        idx_next     = idx_reg;
        rd_addr      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next   = S_HASH;
                    cnt_next     = '0;
                    started_next = !last;
                end
            end
            S_HASH:
            begin
                rd_addr      = cnt_reg;
                wr_pend_next = 1'b1;
                if (cnt_reg == AW'(DIGEST_MAX - 1))
                    state_next = S_HDRAIN;
                else
                    cnt_next = cnt_reg + AW'(1);
            end
            S_HDRAIN:
            begin
                if (last_reg)
                begin
                    state_next = S_EMIT;
                    ecnt_next  = IDX_W'(len_eff - LEN_W'(1));
                end
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                rd_addr     = AW'(ecnt_reg);
                strobe_next = 1'b1;
                idx_next    = ecnt_reg;
                if (ecnt_reg == '0)
                    state_next = S_IDLE;
                else
                    ecnt_next = ecnt_reg - IDX_W'(1);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            ecnt_reg    <= '0;
            wr_pend_reg <= 1'b0;
            started_reg <= 1'b0;
            len_reg     <= LEN_RESET;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ecnt_reg    <= ecnt_next;
            wr_pend_reg <= wr_pend_next;
            started_reg <= started_next;
            strobe_reg  <= strobe_next;
            if (cfg_we)
                len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        idx_reg     <= idx_next;
        if (accept)
        begin
            byte_reg  <= data_byte;
            valid_reg <= byte_valid;
            last_reg  <= last;
            seed_reg  <= !started_reg;
        end
    end

    // digest store
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
            mem[wr_addr_reg] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign strobe      = strobe_reg;
    assign digest_byte = rd_data_reg;
    assign byte_index  = idx_reg;
    assign digest_last = (idx_reg == '0);

endmodule
